// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file rqs_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define RQS_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define RQS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/rqs_pkg.sv =====
// Ready queue scheduler package: entry type, cell control, codes.
// No dependencies.
`timescale 1ns / 1ps

package rqs_pkg;

    localparam int TID_W  = 16;
    localparam int PID_W  = 16;
    localparam int PRIO_W = 8;
    localparam int ST_W   = 2;
    localparam int POL_W  = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [ST_W-1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [ST_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd3;

    localparam logic [POL_W-1:0] POL_FIFO = 2'd0;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // paddr[2] is the register index
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } rqs_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     find;
        logic     newbest;
    } rqs_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_DROP
    } rqs_state_t;

endpackage

// ===== rtl/core/rqs_cell.sv =====
// One queue cell: holds an entry and its min-mark, loads from its right neighbor.
// Depends on rqs_pkg.
`timescale 1ns / 1ps

module rqs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                clk,
    input  rqs_pkg::rqs_ctrl_t  ctrl,
    input  logic [CW-1:0]       count,
    input  rqs_pkg::rqs_entry_t new_entry,
    input  rqs_pkg::rqs_entry_t head_entry,
    input  logic                head_mark,
    input  rqs_pkg::rqs_entry_t nb_entry,
    input  logic                nb_mark,
    output rqs_pkg::rqs_entry_t entry,
    output logic                mark
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    rqs_pkg::rqs_entry_t entry_reg, entry_next;
    logic                mark_reg, mark_next;
    logic                is_load, is_tail;

    assign is_load = (count == IDX_C);
    assign is_tail = (count == IDX_P1);

    always_comb
    begin
        entry_next = entry_reg;
        mark_next  = mark_reg;
        unique case (ctrl.op)
            rqs_pkg::CELL_HOLD:
            begin
            end
            rqs_pkg::CELL_LOAD:
            begin
                if (is_load)
                begin
                    entry_next = new_entry;
                    mark_next  = 1'b0;
                end
            end
            rqs_pkg::CELL_SHIFT:
            begin
                entry_next = nb_entry;
                mark_next  = nb_mark;
            end
            rqs_pkg::CELL_ROTATE:
            begin
                if (is_tail)
                begin
                    entry_next = head_entry;
                    mark_next  = ctrl.find ? ctrl.newbest : head_mark;
                end
                else
                begin
                    entry_next = nb_entry;
                    mark_next  = (ctrl.find && ctrl.newbest) ? 1'b0 : nb_mark;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        mark_reg  <= mark_next;
    end

    assign entry = entry_reg;
    assign mark  = mark_reg;

endmodule

// ===== rtl/core/ready_queue_scheduler.sv =====
// Ready queue scheduler top: APB policy register, sequencer, chain of queue cells.
// Depends on rqs_pkg and rqs_cell.
// Enqueue, FIFO dequeue, empty and full reports: result in the cycle after accept.
// Priority dequeue: busy for one chain rotation to mark the first lowest priority,
// then one to drop it with the result; otherwise one item per cycle.
// Receiver cannot stall. Reset (rst_n, async): queue empty, policy FIFO, no result pending.
`timescale 1ns / 1ps

module ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic [rqs_pkg::TID_W-1:0]    thread_id,
    input  logic [rqs_pkg::PID_W-1:0]    process_id,
    input  logic [rqs_pkg::PRIO_W-1:0]   priority_req,
    output logic                         done,
    output logic [rqs_pkg::ST_W-1:0]     status,
    output logic [rqs_pkg::TID_W-1:0]    out_thread_id,
    output logic [rqs_pkg::PID_W-1:0]    out_process_id,
    output logic [rqs_pkg::PRIO_W-1:0]   out_priority,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rqs_pkg::ADDR_W-1:0]   paddr,
    input  logic [rqs_pkg::DATA_W-1:0]   pwdata,
    output logic [rqs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [rqs_pkg::POL_W-1:0] policy_reg;
    rqs_pkg::rqs_state_t       state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             steps_reg, steps_next;
    logic [rqs_pkg::PRIO_W-1:0] best_reg, best_next;
    logic                      done_reg, done_next;
    logic [rqs_pkg::ST_W-1:0]  status_reg, status_next;
    rqs_pkg::rqs_entry_t       res_reg, res_next;

    rqs_pkg::rqs_ctrl_t        ctrl;
    rqs_pkg::rqs_entry_t       new_entry;
    rqs_pkg::rqs_entry_t       cell_entry [QUEUE_DEPTH];
    logic                      cell_mark  [QUEUE_DEPTH];
    logic                      accept;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == rqs_pkg::REG_POLICY)
                  ? {{(rqs_pkg::DATA_W - rqs_pkg::POL_W){1'b0}}, policy_reg}
                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= rqs_pkg::POL_FIFO;
        else if (cfg_wr && paddr[2] == rqs_pkg::REG_POLICY)
            policy_reg <= pwdata[rqs_pkg::POL_W-1:0];
    end

    assign busy   = (state_reg != rqs_pkg::S_IDLE);
    assign accept = start && !busy;

    assign new_entry.tid  = thread_id;
    assign new_entry.pid  = process_id;
    assign new_entry.prio = priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            rqs_pkg::rqs_entry_t nb_entry;
            logic                nb_mark;
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign nb_entry = '0;
                assign nb_mark  = 1'b0;
            end
            else
            begin : g_mid
                assign nb_entry = cell_entry[gi+1];
                assign nb_mark  = cell_mark[gi+1];
            end
            rqs_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .new_entry  (new_entry),
                .head_entry (cell_entry[0]),
                .head_mark  (cell_mark[0]),
                .nb_entry   (nb_entry),
                .nb_mark    (nb_mark),
                .entry      (cell_entry[gi]),
                .mark       (cell_mark[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        steps_next   = steps_reg;
        best_next    = best_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        res_next     = res_reg;
        ctrl.op      = rqs_pkg::CELL_HOLD;
        ctrl.find    = 1'b0;
        ctrl.newbest = 1'b0;
        unique case (state_reg)
            rqs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (mode == rqs_pkg::MODE_ENQ)
                    begin
                        done_next = 1'b1;
                        if (count_reg == DEPTH_C)
                            status_next = rqs_pkg::ST_FULL;
                        else
                        begin
                            status_next = rqs_pkg::ST_ENQUEUED;
                            ctrl.op     = rqs_pkg::CELL_LOAD;
                            count_next  = count_reg + ONE_C;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = rqs_pkg::ST_EMPTY;
                    end
                    else if (policy_reg == rqs_pkg::POL_FIFO)
                    begin
                        done_next   = 1'b1;
                        status_next = rqs_pkg::ST_DISPATCHED;
                        res_next    = cell_entry[0];
                        ctrl.op     = rqs_pkg::CELL_SHIFT;
                        count_next  = count_reg - ONE_C;
                    end
                    else
                    begin
                        state_next = rqs_pkg::S_FIND;
                        steps_next = count_reg;
                    end
                end
            end
            rqs_pkg::S_FIND:
            begin
                ctrl.op      = rqs_pkg::CELL_ROTATE;
                ctrl.find    = 1'b1;
                ctrl.newbest = (steps_reg == count_reg) || (cell_entry[0].prio < best_reg);
                if (ctrl.newbest)
                    best_next = cell_entry[0].prio;
                steps_next = steps_reg - ONE_C;
                if (steps_reg == ONE_C)
                begin
                    state_next = rqs_pkg::S_DROP;
                    steps_next = count_reg;
                end
            end
            rqs_pkg::S_DROP:
            begin
                if (cell_mark[0])
                begin
                    ctrl.op     = rqs_pkg::CELL_SHIFT;
                    done_next   = 1'b1;
                    status_next = rqs_pkg::ST_DISPATCHED;
                    res_next    = cell_entry[0];
                    count_next  = count_reg - ONE_C;
                end
                else
                    ctrl.op = rqs_pkg::CELL_ROTATE;
                steps_next = steps_reg - ONE_C;
                if (steps_reg == ONE_C)
                    state_next = rqs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rqs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rqs_pkg::S_IDLE;
            count_reg  <= '0;
            steps_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= rqs_pkg::ST_ENQUEUED;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            steps_reg  <= steps_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        res_reg  <= res_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign out_thread_id  = res_reg.tid;
    assign out_process_id = res_reg.pid;
    assign out_priority   = res_reg.prio;

endmodule

// ===== rtl/core/rqs_checker.sv =====
// Port-level checker for the ready queue scheduler, bound to the top level.
// Depends on rqs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rqs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         mode,
    input logic                         done,
    input logic [rqs_pkg::ST_W-1:0]     status,
    input logic [rqs_pkg::TID_W-1:0]    out_thread_id,
    input logic [rqs_pkg::PID_W-1:0]    out_process_id,
    input logic [rqs_pkg::PRIO_W-1:0]   out_priority,
    input logic                         pready
);

    logic enq_beat;
    logic deq_beat;
    logic enq_answer;
    logic plain_result;
    logic ids_zero;
    logic busy_result;
    logic is_dispatch;

    assign enq_beat     = start && !busy && mode == rqs_pkg::MODE_ENQ;
    assign deq_beat     = start && !busy && mode == rqs_pkg::MODE_DEQ;
    assign enq_answer   = done && (status == rqs_pkg::ST_ENQUEUED
                                   || status == rqs_pkg::ST_FULL);
    assign is_dispatch  = (status == rqs_pkg::ST_DISPATCHED);
    assign plain_result = done && !is_dispatch;
    assign ids_zero     = out_thread_id == '0 && out_process_id == '0 && out_priority == '0;
    assign busy_result  = done && busy;

    // an enqueue beat always answers on the next cycle
    `RQS_ASSERT_NEXT(a_enq_answer, clk, rst_n, enq_beat, enq_answer, "enqueue beat without answer")

    // ids are zero unless an entry is dispatched
    `RQS_ASSERT_NOW(a_zero_ids, clk, rst_n, plain_result, ids_zero, "ids set on non-dispatch result")

    // only an accepted dequeue can make the block busy
    `RQS_ASSERT_NOW(a_busy_cause, clk, rst_n, $rose(busy), $past(deq_beat), "busy without dequeue beat")

    // a result inside a busy period is the dispatched entry
    `RQS_ASSERT_NOW(a_busy_result, clk, rst_n, busy_result, is_dispatch, "non-dispatch while busy")

    `RQS_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready, "pready dropped")

endmodule

bind ready_queue_scheduler rqs_checker u_rqs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .done           (done),
    .status         (status),
    .out_thread_id  (out_thread_id),
    .out_process_id (out_process_id),
    .out_priority   (out_priority),
    .pready         (pready)
);
